### sv/kmeans_assign_and_update_assert.svh
// Assertion macros for the k-means assign and update block
`ifndef KMEANS_ASSIGN_AND_UPDATE_ASSERT_SVH
`define KMEANS_ASSIGN_AND_UPDATE_ASSERT_SVH
`define KM_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define KM_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

### sv/km_pkg.sv
// Shared types and constants for the k-means assign and update block
`timescale 1ns / 1ps
`default_nettype none
package km_pkg;
   localparam int MAX_CL = 4;
   localparam int FRAC_BITS = 8;
   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_CENTROID = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_OUT_ASSIGN, ST_DIV_START, ST_DIV_RUN, ST_OUT_MEAN
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_step;
      logic clear_cluster;
      logic load_assign;
      logic load_mean;
      logic next_cluster;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_cluster;
      logic fin;
   } sts_type;
endpackage
`default_nettype wire

### sv/kmeans_assign_and_update.sv
// Top level of the k-means assign and update block
// A point is registered on transfer, then its assignment is loaded into the output
// register once that register is free; no new point is taken before then.
// After a last point, each centroid is computed in the shared bit-serial divider,
// one cluster after another.
// Reset: synchronous, clears control, accumulators and centers to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "kmeans_assign_and_update_assert.svh"
module kmeans_assign_and_update import km_pkg::*; #(
   parameter int NUM_CLUSTERS = 2,
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // point_x, point_y
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // cluster, mean_x, mean_y, empty_res, zero pad
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [COORD_BITS-1:0] cx_ff [MAX_CL];
   logic [COORD_BITS-1:0] cy_ff [MAX_CL];
   logic [2:0] ridx;
   logic [36:0] od;
   logic take;
   cmd_type cmd;
   sts_type sts;
   logic busy;

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[4:2];
   assign csr_prdata = 32'(ridx[0] ? cy_ff[ridx[2:1]] : cx_ff[ridx[2:1]]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_CL; k++) begin
            cx_ff[k] <= '0;
            cy_ff[k] <= '0;
         end
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (ridx[0]) begin
            cy_ff[ridx[2:1]] <= csr_pwdata[COORD_BITS-1:0];
         end else begin
            cx_ff[ridx[2:1]] <= csr_pwdata[COORD_BITS-1:0];
         end
      end
   end

   assign take = busy && rsp_tready;

   km_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .out_busy(busy), .out_take(take), .sts, .cmd
   );

   km_dp #(.NUM_CLUSTERS(NUM_CLUSTERS), .MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS))
   u_dp (
      .clock, .reset, .cmd, .sts, .cx(cx_ff), .cy(cy_ff),
      .pt_x(req_tdata[15:0]), .pt_y(req_tdata[31:16]), .pt_last(req_tlast),
      .out_take(take), .out_busy(busy), .out_data(od)
   );

   assign rsp_tvalid = busy;
   assign rsp_tuser = od[0];
   assign rsp_tdata = {5'd0, od[35:1]};
   assign rsp_tlast = od[36];

   `KM_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `KM_ASSERT_IMP(a_noacc, clock, reset, req_tready, !rsp_tvalid || rsp_tready)
   `KM_ASSERT_NXT(a_acc, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule
`default_nettype wire

### sv/km_ctrl.sv
// Controller state machine for the k-means block
`timescale 1ns / 1ps
`default_nettype none
module km_ctrl import km_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire logic    out_busy,
   input  wire logic    out_take,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !out_busy || out_take;
            if (req_tvalid && req_tready) begin
               cmd.accept = 1'b1;
               state_in = ST_OUT_ASSIGN;
            end
         end
         ST_OUT_ASSIGN: begin
            if (!out_busy || out_take) begin
               cmd.load_assign = 1'b1;
               state_in = sts.fin ? ST_DIV_START : ST_IDLE;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_OUT_MEAN;
            end
         end
         ST_OUT_MEAN: begin
            if (!out_busy || out_take) begin
               cmd.load_mean = 1'b1;
               cmd.clear_cluster = 1'b1;
               cmd.next_cluster = 1'b1;
               state_in = sts.last_cluster ? ST_IDLE : ST_DIV_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### sv/km_dp.sv
// Datapath: distance compare, accumulators, serial divider, output register
`timescale 1ns / 1ps
`default_nettype none
module km_dp import km_pkg::*; #(
   parameter int NUM_CLUSTERS = 2,
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [COORD_BITS-1:0] cx [MAX_CL],
   input  wire logic [COORD_BITS-1:0] cy [MAX_CL],
   input  wire logic [15:0]           pt_x,
   input  wire logic [15:0]           pt_y,
   input  wire logic                  pt_last,
   input  wire logic                  out_take,
   output logic                       out_busy,
   output logic [36:0]                out_data
);
   localparam int NCL = (NUM_CLUSTERS < 1) ? 1 :
                        ((NUM_CLUSTERS > MAX_CL) ? MAX_CL : NUM_CLUSTERS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W = COORD_BITS + CNT_W;
   localparam int CL_W = (NCL > 1) ? $clog2(NCL) : 1;
   localparam int IC_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] sum_x_ff [NCL];
   logic [SUM_W-1:0] sum_y_ff [NCL];
   logic [CNT_W-1:0] cnt_ff [NCL];
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic fin_ff;
   logic [CL_W-1:0] best_in, cl_ff;
   logic [COORD_BITS-1:0] cl_dist [NCL];
   logic [SUM_W-1:0] qx_ff, qy_ff;
   logic [CNT_W:0] rx_ff, ry_ff;
   logic [IC_W-1:0] it_ff;
   logic [CNT_W-1:0] div_cnt;
   logic [CNT_W:0] tx, ty;
   logic busy_ff;
   logic [36:0] data_ff;
   logic [15:0] mx, my;

   function automatic logic [COORD_BITS-1:0] absd(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   always_comb begin
      best_in = '0;
      for (int k = 0; k < NCL; k++) begin
         cl_dist[k] = (absd(px_ff, cx[k]) >> FRAC_BITS) + (absd(py_ff, cy[k]) >> FRAC_BITS);
      end
      for (int k = 1; k < NCL; k++) begin
         if (cl_dist[k] < cl_dist[best_in]) begin
            best_in = CL_W'(k);
         end
      end
   end

   assign div_cnt = cnt_ff[cl_ff];
   assign tx = {rx_ff[CNT_W-1:0], qx_ff[SUM_W-1]};
   assign ty = {ry_ff[CNT_W-1:0], qy_ff[SUM_W-1]};
   assign mx = (div_cnt == '0) ? '0 : 16'(qx_ff);
   assign my = (div_cnt == '0) ? '0 : 16'(qy_ff);

   assign sts.div_done = (it_ff == IC_W'(SUM_W));
   assign sts.last_cluster = (cl_ff == CL_W'(NCL - 1));
   assign sts.fin = fin_ff;
   assign out_busy = busy_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff <= COORD_BITS'(pt_x);
         py_ff <= COORD_BITS'(pt_y);
         fin_ff <= pt_last;
      end
      if (cmd.div_start) begin
         qx_ff <= sum_x_ff[cl_ff];
         qy_ff <= sum_y_ff[cl_ff];
         rx_ff <= '0;
         ry_ff <= '0;
         it_ff <= '0;
      end else if (cmd.div_step && !sts.div_done) begin
         it_ff <= it_ff + 1'b1;
         if (tx >= {1'b0, div_cnt}) begin
            rx_ff <= tx - {1'b0, div_cnt};
            qx_ff <= {qx_ff[SUM_W-2:0], 1'b1};
         end else begin
            rx_ff <= tx;
            qx_ff <= {qx_ff[SUM_W-2:0], 1'b0};
         end
         if (ty >= {1'b0, div_cnt}) begin
            ry_ff <= ty - {1'b0, div_cnt};
            qy_ff <= {qy_ff[SUM_W-2:0], 1'b1};
         end else begin
            ry_ff <= ty;
            qy_ff <= {qy_ff[SUM_W-2:0], 1'b0};
         end
      end
      if (cmd.load_assign) begin
         data_ff <= {!fin_ff, 1'b0, 16'd0, 16'd0, 2'(best_in), KIND_ASSIGN};
      end else if (cmd.load_mean) begin
         data_ff <= {sts.last_cluster, div_cnt == '0, my, mx, 2'(cl_ff), KIND_CENTROID};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cl_ff <= '0;
         for (int k = 0; k < NCL; k++) begin
            sum_x_ff[k] <= '0;
            sum_y_ff[k] <= '0;
            cnt_ff[k] <= '0;
         end
      end else begin
         if (cmd.load_assign || cmd.load_mean) begin
            busy_ff <= 1'b1;
         end else if (out_take) begin
            busy_ff <= 1'b0;
         end
         if (cmd.load_assign) begin
            if (cnt_ff[best_in] < CNT_W'(MAX_POINTS)) begin
               sum_x_ff[best_in] <= sum_x_ff[best_in] + SUM_W'(px_ff);
               sum_y_ff[best_in] <= sum_y_ff[best_in] + SUM_W'(py_ff);
               cnt_ff[best_in] <= cnt_ff[best_in] + 1'b1;
            end
         end
         if (cmd.clear_cluster) begin
            sum_x_ff[cl_ff] <= '0;
            sum_y_ff[cl_ff] <= '0;
            cnt_ff[cl_ff] <= '0;
         end
         if (cmd.next_cluster) begin
            cl_ff <= sts.last_cluster ? '0 : cl_ff + 1'b1;
         end
      end
   end
endmodule
`default_nettype wire
